/* sv/nbc_pkg.sv */
// Shared widths and constants for the naive Bayes classifier.
// No dependencies; nbc_ln and the top level import this package.
package nbc_pkg;

   localparam int FEAT_W      = 20;  // signed Q10.10 feature
   localparam int IN_FEATURES = 4;   // features carried by one request word
   localparam int VFLOOR_W    = 20;  // variance floor register, Q10.10
   localparam int DVS_W       = 32;  // divisor width of the shared divider
   localparam int HINV_W      = 32;  // half inverse variance
   localparam int LN_W        = 21;  // natural log, Q5.16, unsigned
   localparam int BIAS_W      = 32;  // class bias, Q16.16, signed
   localparam int SCORE_W     = 64;  // posterior score accumulator
   localparam int MANT_W      = 16;

   localparam logic [1:0] OP_TRAIN   = 2'd0;
   localparam logic [1:0] OP_FINISH  = 2'd1;
   localparam logic [1:0] OP_PREDICT = 2'd2;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_MODEL = 1'b1;

   localparam logic [DVS_W-1:0] TWO_POW_31 = 32'h8000_0000;
   localparam logic [15:0]      LN2_Q16    = 16'd45426;

   // round(65536 * log2(1 + k/16)) for the four bits below the leading one.
   localparam logic [MANT_W-1:0] LOG2_MANT [16] = '{
      16'd0,     16'd5732,  16'd11136, 16'd16248,
      16'd21098, 16'd25711, 16'd30109, 16'd34312,
      16'd38336, 16'd42196, 16'd45904, 16'd49472,
      16'd52911, 16'd56228, 16'd59434, 16'd62534
   };

endpackage

/* sv/nbc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module nbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/nbc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module nbc_div #(
   parameter int DIVIDEND_W = 56,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quot_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  run_ff;
   logic                  done_ff;

   logic [DIVISOR_W:0]    trial;
   logic                  fits;
   logic [DIVISOR_W-1:0]  rem_in;

   always_comb begin
      trial  = {rem_ff, quot_ff[DIVIDEND_W-1]};
      fits   = (trial >= {1'b0, dvs_ff});
      rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quot_ff <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= {quot_ff[DIVIDEND_W-2:0], fits};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

/* sv/nbc_ln.sv */
// Natural logarithm in Q5.16 of a nonzero 32-bit integer.
// Depends on nbc_pkg for the log2 mantissa table and ln 2.
module nbc_ln
   import nbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      operand,
   output logic             done,
   output logic [LN_W-1:0]  result
);

   typedef enum logic [1:0] {
      L_IDLE,
      L_NORM,
      L_MUL
   } ln_state_type;

   ln_state_type    state_ff;
   logic [31:0]     x_ff;
   logic [4:0]      e_ff;
   logic            done_ff;
   logic [LN_W-1:0] result_ff;

   logic [20:0]     log2_val;
   logic [36:0]     ln_prod;

   always_comb begin
      log2_val = {e_ff, LOG2_MANT[x_ff[30:27]]};
      ln_prod  = 37'(log2_val) * 37'(LN2_Q16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  x_ff     <= operand;
                  e_ff     <= 5'd31;
                  state_ff <= L_NORM;
               end
            end
            L_NORM: begin
               // Shift until the leading one sits in the top bit.
               if (x_ff[31] || e_ff == 5'd0) begin
                  state_ff <= L_MUL;
               end else begin
                  x_ff <= {x_ff[30:0], 1'b0};
                  e_ff <= e_ff - 1'b1;
               end
            end
            L_MUL: begin
               result_ff <= ln_prod[36:16];
               done_ff   <= 1'b1;
               state_ff  <= L_IDLE;
            end
            default: begin
               state_ff <= L_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

/* sv/gaussian_naive_bayes_classifier.sv */
// Gaussian naive Bayes classifier, top level: sequencer, statistics and model memories.
// Depends on nbc_pkg, nbc_ram, nbc_div and nbc_ln.
//
// A request word is taken at a rising edge with start high and busy low and carries one
// of three opcodes. Train adds a labeled sample to the per-class count, feature sums and
// sums of squares; finish turns them into means, floored variances and log-domain class
// biases; predict scores every trained class and answers with the best label (lowest
// index on ties) or with status 1 when no model is trained. Only predict gives a
// response word, shown on the rsp_ ports for exactly one cycle while rsp_strobe is high;
// the receiver cannot stall it, so it must take every response as it comes. A train word
// does a read-modify-write of each statistics entry through the single read port. A
// predict word runs, for each trained class, the per-term chain of memory read,
// difference, square, split multiply and accumulate. A finish word, for each trained
// class, is paced by the three bit-serial divisions per feature and the leading-one
// search of the log unit. The variance floor register may only be written while busy
// is low.
module gaussian_naive_bayes_classifier
   import nbc_pkg::*;
#(
   parameter int NUM_FEATURES = 4,
   parameter int NUM_CLASSES  = 3,
   parameter int COUNT_BITS   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_opcode,
   input  logic [1:0]               req_class_label,
   input  logic signed [FEAT_W-1:0] req_feature_s,
   input  logic signed [FEAT_W-1:0] req_feature_d,
   input  logic signed [FEAT_W-1:0] req_feature_s_rate,
   input  logic signed [FEAT_W-1:0] req_feature_d_rate,
   output logic                     rsp_strobe,
   output logic [1:0]               rsp_predicted_label,
   output logic                     rsp_status,
   input  logic                     csr_write_enable,
   input  logic [VFLOOR_W-1:0]      csr_write_data
);

   localparam int CNT_W   = COUNT_BITS;
   localparam int SUM_W   = FEAT_W + CNT_W;
   localparam int SQ_W    = 2 * FEAT_W + CNT_W;
   localparam int DIV_W   = SQ_W;
   localparam int ENTRIES = NUM_CLASSES * NUM_FEATURES;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int CLS_W   = $clog2(NUM_CLASSES);
   localparam int FCNT_W  = $clog2(NUM_FEATURES + 1);
   localparam int STAT_W  = SUM_W + SQ_W;
   localparam int MODEL_W = FEAT_W + HINV_W;
   localparam int QR_W    = FEAT_W + CNT_W + 1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TR_RD,
      ST_TR_WR,
      ST_FN_CLS,
      ST_FN_LNN_W,
      ST_FN_RD,
      ST_FN_DAT,
      ST_FN_DIVA,
      ST_FN_DIVA_W,
      ST_FN_QR,
      ST_FN_M1,
      ST_FN_M2,
      ST_FN_T,
      ST_FN_DIVB,
      ST_FN_DIVB_W,
      ST_FN_CMP,
      ST_FN_VAR,
      ST_FN_DIVC,
      ST_FN_DIVC_W,
      ST_FN_LNV,
      ST_FN_LNV_W,
      ST_FN_WR,
      ST_PR_CLS,
      ST_PR_RD,
      ST_PR_DIF,
      ST_PR_SQ,
      ST_PR_MUL,
      ST_PR_ACC,
      ST_PR_CMP
   } state_type;

   // Control state.
   state_type            state_ff;
   logic                 model_valid_ff;
   logic [CNT_W-1:0]     count_ff [NUM_CLASSES];
   logic [VFLOOR_W-1:0]  vfloor_ff;
   logic                 rsp_strobe_ff;
   logic [1:0]           rsp_label_ff;
   logic                 rsp_status_ff;

   // Sequencer position and latched request word.
   logic [CLS_W-1:0]        cls_ff;
   logic [FCNT_W-1:0]       f_ff;
   logic signed [FEAT_W-1:0] feat_ff [IN_FEATURES];

   // Finish datapath.
   logic signed [SUM_W-1:0]  s_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic signed [FEAT_W-1:0] q_ff;
   logic [CNT_W-1:0]         r_ff;
   logic [2*FEAT_W-1:0]      qq_ff;
   logic signed [QR_W-1:0]   qr_ff;
   logic [SQ_W-1:0]          qqn_ff;
   logic [SQ_W-1:0]          t_ff;
   logic [DIV_W-1:0]         a_ff;
   logic [2*CNT_W-1:0]       nb_ff;
   logic [2*CNT_W-1:0]       rr_ff;
   logic [DVS_W-1:0]         v_ff;
   logic signed [BIAS_W-1:0] bias_acc_ff;
   logic signed [BIAS_W-1:0] bias_ff [NUM_CLASSES];

   // Predict datapath.
   logic signed [FEAT_W:0]   d_ff;
   logic [HINV_W-1:0]        h_ff;
   logic [2*FEAT_W+1:0]      d2_ff;
   logic [HINV_W+21:0]       hi_ff;
   logic [HINV_W+19:0]       lo_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic signed [SCORE_W-1:0] best_score_ff;
   logic [CLS_W-1:0]         best_ff;
   logic                     found_ff;

   // Memory and unit connections.
   logic [ADDR_W-1:0]  addr;
   logic               stat_we;
   logic [STAT_W-1:0]  stat_wdata;
   logic [STAT_W-1:0]  stat_rdata;
   logic               model_we;
   logic [MODEL_W-1:0] model_wdata;
   logic [MODEL_W-1:0] model_rdata;
   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic [DVS_W-1:0]   div_divisor;
   logic               div_done;
   logic [DIV_W-1:0]   div_quot;
   logic [DVS_W-1:0]   div_rem;
   logic               ln_start;
   logic [31:0]        ln_operand;
   logic               ln_done;
   logic [LN_W-1:0]    ln_result;

   // Combinational helpers.
   logic [CNT_W-1:0]          n_cur;
   logic                      last_f;
   logic                      last_cls;
   logic signed [FEAT_W-1:0]  feat_sel;
   logic signed [SUM_W-1:0]   old_sum;
   logic [SQ_W-1:0]           old_sq;
   logic signed [2*FEAT_W-1:0] x_sq;
   logic [SUM_W-1:0]          s_abs;
   logic                      any_trained;
   logic [VFLOOR_W-1:0]       vfloor_eff;
   logic signed [SQ_W+1:0]    t_wide;
   logic [DIV_W-1:0]          var20;
   logic [DIV_W-1:0]          var10;
   logic signed [BIAS_W-1:0]  bias_next;
   logic signed [FEAT_W-1:0]  mean_rd;
   logic signed [2*FEAT_W+1:0] d_sq;
   logic [HINV_W+20:0]        quad_low;
   logic [HINV_W+22:0]        quad;
   logic                      take_best;
   logic [CLS_W-1:0]          best_now;
   logic [FEAT_W:0]           q_neg_base;

   always_comb begin
      n_cur    = count_ff[cls_ff];
      last_f   = (f_ff == FCNT_W'(NUM_FEATURES - 1));
      last_cls = (cls_ff == CLS_W'(NUM_CLASSES - 1));
      addr     = ADDR_W'(int'(cls_ff) * NUM_FEATURES + int'(f_ff));

      // Features past the four in the request word read as zero.
      feat_sel = '0;
      for (int i = 0; i < IN_FEATURES; i++) begin
         if (int'(f_ff) == i) begin
            feat_sel = feat_ff[i];
         end
      end

      // A class that never counted a sample has never had its entries written;
      // its sums are zero.
      old_sum = (n_cur == '0) ? '0 : signed'(stat_rdata[STAT_W-1 -: SUM_W]);
      old_sq  = (n_cur == '0) ? '0 : stat_rdata[SQ_W-1:0];
      x_sq    = feat_sel * feat_sel;

      stat_we    = (state_ff == ST_TR_WR);
      stat_wdata = {SUM_W'(old_sum + SUM_W'(feat_sel)),
                    SQ_W'(old_sq + SQ_W'(unsigned'(x_sq)))};

      any_trained = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         any_trained = any_trained | (count_ff[c] != '0);
      end

      vfloor_eff = (vfloor_ff == '0) ? VFLOOR_W'(1) : vfloor_ff;
      s_abs      = s_ff[SUM_W-1] ? unsigned'(-s_ff) : unsigned'(s_ff);
      q_neg_base = (FEAT_W + 1)'(div_quot);

      // t = sq - q*(s + r), rewritten with s = q*n + r as sq - q*q*n - 2*q*r.
      t_wide = signed'((SQ_W + 2)'(sq_ff)) - signed'((SQ_W + 2)'(qqn_ff))
               - ((SQ_W + 2)'(qr_ff) <<< 1);

      // The fraction term of the exact variance is either 0 or -1.
      var20 = a_ff - DIV_W'(nb_ff < rr_ff);
      var10 = var20 >> 10;

      bias_next = bias_acc_ff - BIAS_W'(ln_result >> 1);

      model_we    = (state_ff == ST_FN_WR);
      model_wdata = {q_ff, div_quot[HINV_W-1:0]};
      mean_rd     = signed'(model_rdata[MODEL_W-1 -: FEAT_W]);

      d_sq     = d_ff * d_ff;
      quad_low = ((HINV_W + 21)'(hi_ff[5:0]) << 20) + (HINV_W + 21)'(lo_ff);
      quad     = (HINV_W + 23)'(hi_ff >> 6) + (HINV_W + 23)'(quad_low >> 26);

      take_best = !found_ff || (score_ff > best_score_ff);
      best_now  = take_best ? cls_ff : best_ff;

      div_start    = (state_ff == ST_FN_DIVA) || (state_ff == ST_FN_DIVB)
                     || (state_ff == ST_FN_DIVC);
      div_dividend = DIV_W'(TWO_POW_31);
      div_divisor  = v_ff;
      case (state_ff)
         ST_FN_DIVA: begin
            div_dividend = DIV_W'(s_abs);
            div_divisor  = DVS_W'(n_cur);
         end
         ST_FN_DIVB: begin
            div_dividend = t_ff;
            div_divisor  = DVS_W'(n_cur);
         end
         default: begin
            div_dividend = DIV_W'(TWO_POW_31);
            div_divisor  = v_ff;
         end
      endcase

      ln_start   = (state_ff == ST_FN_LNV) || ((state_ff == ST_FN_CLS) && (n_cur != '0));
      ln_operand = (state_ff == ST_FN_CLS) ? 32'(n_cur) : v_ff;
   end

   nbc_ram #(
      .WIDTH (STAT_W),
      .DEPTH (ENTRIES)
   ) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_we),
      .wr_addr (addr),
      .wr_data (stat_wdata),
      .rd_addr (addr),
      .rd_data (stat_rdata)
   );

   nbc_ram #(
      .WIDTH (MODEL_W),
      .DEPTH (ENTRIES)
   ) u_model_ram (
      .clock   (clock),
      .wr_en   (model_we),
      .wr_addr (addr),
      .wr_data (model_wdata),
      .rd_addr (addr),
      .rd_data (model_rdata)
   );

   nbc_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (DVS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   nbc_ln u_ln (
      .clock   (clock),
      .reset   (reset),
      .start   (ln_start),
      .operand (ln_operand),
      .done    (ln_done),
      .result  (ln_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         model_valid_ff <= 1'b0;
         vfloor_ff      <= VFLOOR_W'(1);
         rsp_strobe_ff  <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            count_ff[c] <= '0;
         end
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_write_enable) begin
            vfloor_ff <= csr_write_data;
         end

         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  feat_ff[0] <= req_feature_s;
                  feat_ff[1] <= req_feature_d;
                  feat_ff[2] <= req_feature_s_rate;
                  feat_ff[3] <= req_feature_d_rate;
                  f_ff       <= '0;
                  case (req_opcode)
                     OP_TRAIN: begin
                        // Out-of-range labels are dropped; a saturated class drops the
                        // whole sample so its sums stay consistent with its count.
                        if (int'(req_class_label) < NUM_CLASSES) begin
                           model_valid_ff <= 1'b0;
                           cls_ff         <= CLS_W'(req_class_label);
                           if (count_ff[CLS_W'(req_class_label)] != '1) begin
                              state_ff <= ST_TR_RD;
                           end
                        end
                     end
                     OP_FINISH: begin
                        model_valid_ff <= any_trained;
                        cls_ff         <= '0;
                        state_ff       <= ST_FN_CLS;
                     end
                     OP_PREDICT: begin
                        if (model_valid_ff) begin
                           cls_ff   <= '0;
                           found_ff <= 1'b0;
                           state_ff <= ST_PR_CLS;
                        end else begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_label_ff  <= 2'd0;
                           rsp_status_ff <= STATUS_NO_MODEL;
                        end
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end

            // Training: read an entry, write it back with the sample added.
            ST_TR_RD: begin
               state_ff <= ST_TR_WR;
            end
            ST_TR_WR: begin
               if (last_f) begin
                  count_ff[cls_ff] <= n_cur + 1'b1;
                  state_ff         <= ST_IDLE;
               end else begin
                  f_ff     <= f_ff + 1'b1;
                  state_ff <= ST_TR_RD;
               end
            end

            // Finish: one class at a time, one feature at a time.
            ST_FN_CLS: begin
               f_ff <= '0;
               if (n_cur != '0) begin
                  state_ff <= ST_FN_LNN_W;
               end else if (last_cls) begin
                  state_ff <= ST_IDLE;
               end else begin
                  cls_ff <= cls_ff + 1'b1;
               end
            end
            ST_FN_LNN_W: begin
               if (ln_done) begin
                  bias_acc_ff <= BIAS_W'(ln_result);
                  state_ff    <= ST_FN_RD;
               end
            end
            ST_FN_RD: begin
               state_ff <= ST_FN_DAT;
            end
            ST_FN_DAT: begin
               s_ff     <= signed'(stat_rdata[STAT_W-1 -: SUM_W]);
               sq_ff    <= stat_rdata[SQ_W-1:0];
               state_ff <= ST_FN_DIVA;
            end
            ST_FN_DIVA: begin
               state_ff <= ST_FN_DIVA_W;
            end
            ST_FN_DIVA_W: begin
               if (div_done) begin
                  state_ff <= ST_FN_QR;
               end
            end
            ST_FN_QR: begin
               // Floor division of a signed sum from the magnitude quotient.
               if (s_ff[SUM_W-1] && div_rem != '0) begin
                  q_ff <= FEAT_W'(-(q_neg_base + 1'b1));
                  r_ff <= n_cur - div_rem[CNT_W-1:0];
               end else if (s_ff[SUM_W-1]) begin
                  q_ff <= FEAT_W'(-q_neg_base);
                  r_ff <= '0;
               end else begin
                  q_ff <= signed'(div_quot[FEAT_W-1:0]);
                  r_ff <= div_rem[CNT_W-1:0];
               end
               state_ff <= ST_FN_M1;
            end
            ST_FN_M1: begin
               qq_ff    <= unsigned'((2 * FEAT_W)'(q_ff * q_ff));
               qr_ff    <= QR_W'(q_ff) * signed'(QR_W'(r_ff));
               state_ff <= ST_FN_M2;
            end
            ST_FN_M2: begin
               qqn_ff   <= SQ_W'(qq_ff) * SQ_W'(n_cur);
               state_ff <= ST_FN_T;
            end
            ST_FN_T: begin
               t_ff     <= t_wide[SQ_W-1:0];
               state_ff <= ST_FN_DIVB;
            end
            ST_FN_DIVB: begin
               state_ff <= ST_FN_DIVB_W;
            end
            ST_FN_DIVB_W: begin
               if (div_done) begin
                  state_ff <= ST_FN_CMP;
               end
            end
            ST_FN_CMP: begin
               a_ff     <= div_quot;
               nb_ff    <= (2 * CNT_W)'(n_cur) * (2 * CNT_W)'(div_rem[CNT_W-1:0]);
               rr_ff    <= (2 * CNT_W)'(r_ff) * (2 * CNT_W)'(r_ff);
               state_ff <= ST_FN_VAR;
            end
            ST_FN_VAR: begin
               if (var10 < DIV_W'(vfloor_eff)) begin
                  v_ff <= DVS_W'(vfloor_eff);
               end else begin
                  v_ff <= var10[DVS_W-1:0];
               end
               state_ff <= ST_FN_DIVC;
            end
            ST_FN_DIVC: begin
               state_ff <= ST_FN_DIVC_W;
            end
            ST_FN_DIVC_W: begin
               if (div_done) begin
                  state_ff <= ST_FN_LNV;
               end
            end
            ST_FN_LNV: begin
               state_ff <= ST_FN_LNV_W;
            end
            ST_FN_LNV_W: begin
               if (ln_done) begin
                  state_ff <= ST_FN_WR;
               end
            end
            ST_FN_WR: begin
               bias_acc_ff <= bias_next;
               if (!last_f) begin
                  f_ff     <= f_ff + 1'b1;
                  state_ff <= ST_FN_RD;
               end else begin
                  bias_ff[cls_ff] <= bias_next;
                  if (last_cls) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     cls_ff   <= cls_ff + 1'b1;
                     state_ff <= ST_FN_CLS;
                  end
               end
            end

            // Predict: score each trained class term by term.
            ST_PR_CLS: begin
               f_ff <= '0;
               if (n_cur != '0) begin
                  score_ff <= SCORE_W'(bias_ff[cls_ff]);
                  state_ff <= ST_PR_RD;
               end else if (last_cls) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_label_ff  <= found_ff ? 2'(best_ff) : 2'd0;
                  rsp_status_ff <= found_ff ? STATUS_OK : STATUS_NO_MODEL;
                  state_ff      <= ST_IDLE;
               end else begin
                  cls_ff <= cls_ff + 1'b1;
               end
            end
            ST_PR_RD: begin
               state_ff <= ST_PR_DIF;
            end
            ST_PR_DIF: begin
               d_ff     <= (FEAT_W + 1)'(feat_sel) - (FEAT_W + 1)'(mean_rd);
               h_ff     <= model_rdata[HINV_W-1:0];
               state_ff <= ST_PR_SQ;
            end
            ST_PR_SQ: begin
               d2_ff    <= unsigned'(d_sq);
               state_ff <= ST_PR_MUL;
            end
            ST_PR_MUL: begin
               hi_ff    <= (HINV_W + 22)'(d2_ff[2*FEAT_W+1:20]) * (HINV_W + 22)'(h_ff);
               lo_ff    <= (HINV_W + 20)'(d2_ff[19:0]) * (HINV_W + 20)'(h_ff);
               state_ff <= ST_PR_ACC;
            end
            ST_PR_ACC: begin
               score_ff <= score_ff - signed'(SCORE_W'(quad));
               if (last_f) begin
                  state_ff <= ST_PR_CMP;
               end else begin
                  f_ff     <= f_ff + 1'b1;
                  state_ff <= ST_PR_RD;
               end
            end
            ST_PR_CMP: begin
               found_ff <= 1'b1;
               best_ff  <= best_now;
               if (take_best) begin
                  best_score_ff <= score_ff;
               end
               if (last_cls) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_label_ff  <= 2'(best_now);
                  rsp_status_ff <= STATUS_OK;
                  state_ff      <= ST_IDLE;
               end else begin
                  cls_ff   <= cls_ff + 1'b1;
                  state_ff <= ST_PR_CLS;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_predicted_label = rsp_label_ff;
   assign rsp_status          = rsp_status_ff;

endmodule
